[rtl/core/mrrc_pkg.sv]
// Package for the Modbus RTU response checker core.
// Holds the request codes, status codes, register indexes, result record and CRC-16 step.
// No dependencies.
package mrrc_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXCEPTION = 2'd1,
		ST_SHORT     = 2'd2,
		ST_CRC_ERROR = 2'd3
	} status_t;

	localparam logic [2:0] REG_EXPECTED_ADDRESS = 3'd0;
	localparam logic [2:0] REG_REGISTER_COUNT   = 3'd1;
	localparam logic [2:0] REG_DATA_BYTE_COUNT  = 3'd2;
	localparam logic [2:0] REG_FIRST_TIMEOUT    = 3'd3;
	localparam logic [2:0] REG_GAP_TIMEOUT      = 3'd4;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  EXC_FLAG       = 8'h80;
	localparam logic [7:0]  EXC_DEFAULT    = 8'd3;
	localparam logic [7:0]  MAX_LENGTH     = 8'd255;
	localparam logic [7:0]  MIN_CRC_LENGTH = 8'd6;
	localparam logic [2:0]  HDR_SHORT      = 3'd3;
	localparam logic [2:0]  HDR_LONG       = 3'd4;

	typedef struct packed {
		logic [7:0] frame_length;
		logic [7:0] exception_code;
		logic [1:0] status;
		logic [7:0] byte_index;
		logic [7:0] data_byte;
		logic       kind;
		logic       last;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/modbus_rtu_response_checker_core.sv]
// Modbus RTU response checker, top level.
// Frame tracking, running CRC-16 and a four-entry result queue; uses mrrc_pkg.
//
// One request (start, received byte or millisecond tick) is accepted per clock cycle while
// s_axis_tready is high, and its results enter the result queue at the same edge, so a result
// can leave in the next cycle. A byte that closes a frame yields two results, the byte and the
// frame status, and the output side passes them one at a time; s_axis_tready is high while the
// four-entry result queue has at least two free places, so a steady rate of one request per cycle
// holds while the output takes one result per cycle and at most every other request closes a frame.
module modbus_rtu_response_checker_core
	import mrrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index, [17:16] status,
	                                    // [25:18] exception_code, [33:26] frame_length, zero above
	output logic        m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast    // last
);

	logic [7:0]  expected_address_q;
	logic [6:0]  register_count_q;
	logic [7:0]  data_byte_count_q;
	logic [7:0]  first_timeout_q;
	logic [7:0]  gap_timeout_q;

	logic        receiving_q;
	logic [7:0]  stored_length_q;
	logic [2:0]  header_length_q;
	logic [7:0]  function_byte_q;
	logic [7:0]  third_byte_q;
	logic [15:0] crc_q;
	logic [7:0]  delayed0_q;
	logic [7:0]  delayed1_q;
	logic [7:0]  timeout_q;

	logic        receiving_d;
	logic [7:0]  stored_length_d;
	logic [2:0]  header_length_d;
	logic [7:0]  function_byte_d;
	logic [7:0]  third_byte_d;
	logic [15:0] crc_d;
	logic [7:0]  delayed0_d;
	logic [7:0]  delayed1_d;
	logic [7:0]  timeout_d;

	result_t     res0;
	result_t     res1;
	logic [1:0]  res_count;

	result_t     queue_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  fill_q;

	logic        accept;
	logic        pop;
	opcode_t     op;
	logic [7:0]  rx;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign pop    = m_axis_tvalid && m_axis_tready;
	assign op     = opcode_t'(s_axis_tuser);
	assign rx     = s_axis_tdata;

	always_comb begin
		logic [8:0]  data_len;
		logic [9:0]  target;
		logic [7:0]  tick_left;
		logic        finish;
		result_t     status_res;

		receiving_d     = receiving_q;
		stored_length_d = stored_length_q;
		header_length_d = header_length_q;
		function_byte_d = function_byte_q;
		third_byte_d    = third_byte_q;
		crc_d           = crc_q;
		delayed0_d      = delayed0_q;
		delayed1_d      = delayed1_q;
		timeout_d       = timeout_q;
		res0            = '0;
		res1            = '0;
		res_count       = 2'd0;
		finish          = 1'b0;
		data_len        = '0;
		target          = '0;
		tick_left       = '0;
		status_res      = '0;

		case (op)
			OP_START: begin
				receiving_d     = 1'b1;
				stored_length_d = 8'd0;
				header_length_d = HDR_SHORT;
				function_byte_d = 8'd0;
				third_byte_d    = 8'd0;
				crc_d           = CRC_INIT;
				delayed0_d      = 8'd0;
				delayed1_d      = 8'd0;
				timeout_d       = first_timeout_q;
			end
			OP_TICK: begin
				if (receiving_q) begin
					tick_left = (timeout_q != 8'd0) ? timeout_q - 8'd1 : 8'd0;
					timeout_d = tick_left;
					finish    = (tick_left == 8'd0);
				end
			end
			OP_BYTE: begin
				if (receiving_q) begin
					timeout_d = gap_timeout_q;
					if (stored_length_q != 8'd0 || rx == expected_address_q) begin
						res0.data_byte  = rx;
						res0.byte_index = stored_length_q;
						res_count       = 2'd1;
						if (stored_length_q >= 8'd2) begin
							crc_d = crc16_byte(crc_q, delayed0_q);
						end
						delayed0_d = delayed1_q;
						delayed1_d = rx;
						if (stored_length_q == 8'd1) begin
							function_byte_d = rx;
						end
						if (stored_length_q == 8'd2) begin
							third_byte_d = rx;
							if (function_byte_q inside {8'd5, 8'd6, 8'd15, 8'd16}) begin
								header_length_d = HDR_LONG;
							end
						end
						stored_length_d = stored_length_q + 8'd1;
						data_len = (data_byte_count_q != 8'd0) ? {1'b0, data_byte_count_q}
						                                       : {1'b0, register_count_q, 1'b0};
						target = {1'b0, data_len} + {7'd0, header_length_d} + 10'd2;
						finish = ({2'd0, stored_length_d} >= target)
						      || (stored_length_d == MAX_LENGTH);
					end
				end
			end
			default: begin
			end
		endcase

		status_res.kind         = 1'b1;
		status_res.last         = 1'b1;
		status_res.frame_length = stored_length_d;
		if (stored_length_d < 8'd2) begin
			status_res.status = ST_SHORT;
		end else if ((function_byte_d & EXC_FLAG) != 8'd0) begin
			status_res.status         = ST_EXCEPTION;
			status_res.exception_code = (third_byte_d != 8'd0) ? third_byte_d : EXC_DEFAULT;
		end else if (stored_length_d < MIN_CRC_LENGTH) begin
			status_res.status = ST_SHORT;
		end else if ({delayed1_d, delayed0_d} != crc_d) begin
			status_res.status = ST_CRC_ERROR;
		end else begin
			status_res.status = ST_OK;
		end

		if (finish) begin
			receiving_d = 1'b0;
			if (res_count == 2'd1) begin
				res1      = status_res;
				res_count = 2'd2;
			end else begin
				res0      = status_res;
				res_count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_address_q <= 8'd0;
			register_count_q   <= 7'd1;
			data_byte_count_q  <= 8'd0;
			first_timeout_q    <= 8'd10;
			gap_timeout_q      <= 8'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPECTED_ADDRESS: expected_address_q <= cfg_data;
				REG_REGISTER_COUNT:   register_count_q   <= cfg_data[6:0];
				REG_DATA_BYTE_COUNT:  data_byte_count_q  <= cfg_data;
				REG_FIRST_TIMEOUT:    first_timeout_q    <= cfg_data;
				REG_GAP_TIMEOUT:      gap_timeout_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q     <= 1'b0;
			stored_length_q <= 8'd0;
			header_length_q <= HDR_SHORT;
			function_byte_q <= 8'd0;
			third_byte_q    <= 8'd0;
			crc_q           <= CRC_INIT;
			delayed0_q      <= 8'd0;
			delayed1_q      <= 8'd0;
			timeout_q       <= 8'd0;
		end else if (accept) begin
			receiving_q     <= receiving_d;
			stored_length_q <= stored_length_d;
			header_length_q <= header_length_d;
			function_byte_q <= function_byte_d;
			third_byte_q    <= third_byte_d;
			crc_q           <= crc_d;
			delayed0_q      <= delayed0_d;
			delayed1_q      <= delayed1_d;
			timeout_q       <= timeout_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_count != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (accept && res_count == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			fill_q   <= 3'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + res_count;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			fill_q <= fill_q + (accept ? {1'b0, res_count} : 3'd0) - {2'd0, pop};
		end
	end

	assign s_axis_tready = (fill_q <= 3'd2);
	assign m_axis_tvalid = (fill_q != 3'd0);
	assign m_axis_tdata  = {6'd0,
	                        queue_q[rd_ptr_q].frame_length,
	                        queue_q[rd_ptr_q].exception_code,
	                        queue_q[rd_ptr_q].status,
	                        queue_q[rd_ptr_q].byte_index,
	                        queue_q[rd_ptr_q].data_byte};
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;

endmodule
